### hw/rtl/hts_pkg.sv
// Shared types, constants and the segment decoder of the hysteresis thermostat.
package hts_pkg;

  localparam int unsigned AdcW    = 10;
  localparam int unsigned BtnW    = 3;
  localparam int unsigned LimW    = 7;
  localparam int unsigned TempW   = 14;
  localparam int unsigned AccW    = 30;
  localparam int unsigned MulW    = 20;
  localparam int unsigned CntW    = 4;
  localparam int unsigned SegW    = 8;
  localparam int unsigned BcdW    = 16;
  localparam int unsigned InDataW = 16;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [AccW-1:0] QuadA = AccW'(321);
  localparam logic [MulW-1:0] QuadB = MulW'(353501);
  localparam logic [AccW-1:0] QuadC = AccW'(51963494);

  localparam logic [CntW-1:0] MulLast = CntW'(AdcW - 1);
  localparam logic [CntW-1:0] BcdLast = CntW'(TempW - 1);

  localparam logic [LimW-1:0] LimMax = LimW'(100);
  localparam logic [LimW-1:0] LimMin = LimW'(30);
  localparam logic [LimW:0]   LimGap = (LimW + 1)'(2);

  localparam logic [TempW-1:0] Thousand    = TempW'(1000);
  localparam logic [TempW-1:0] TenThousand = TempW'(10000);

  localparam logic [1:0] ModeTemp  = 2'd0;
  localparam logic [1:0] ModeUpper = 2'd1;
  localparam logic [1:0] ModeLower = 2'd2;

  localparam logic [1:0] StrobeNone  = 2'd0;
  localparam logic [1:0] StrobeUpper = 2'd1;
  localparam logic [1:0] StrobeLower = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgLower = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgUpper = 1'b1;

  localparam logic [SegW-1:0] SegPoint = 8'h80;

  typedef enum logic [7:0] {
    StIdle = 8'b0000_0001,
    StMul1 = 8'b0000_0010,
    StAddB = 8'b0000_0100,
    StMul2 = 8'b0000_1000,
    StAddC = 8'b0001_0000,
    StUpd  = 8'b0010_0000,
    StBcd  = 8'b0100_0000,
    StDone = 8'b1000_0000
  } state_e;

  function automatic logic [SegW-1:0] digit_seg(input logic [3:0] d);
    logic [SegW-1:0] s;
    case (d)
      4'd0: s = 8'h77;
      4'd1: s = 8'h24;
      4'd2: s = 8'h5D;
      4'd3: s = 8'h6D;
      4'd4: s = 8'h2E;
      4'd5: s = 8'h6B;
      4'd6: s = 8'h7B;
      4'd7: s = 8'h25;
      4'd8: s = 8'h7F;
      4'd9: s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [LimW+5:0] times50(input logic [LimW-1:0] h);
    return {1'b0, h, 5'b0} + {2'b0, h, 4'b0} + {5'b0, h, 1'b0};
  endfunction

endpackage

### hw/rtl/hysteresis_thermostat_with_display.sv
// Top level of the hysteresis thermostat with limit menu and three-digit display.
//
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser kind, tdata adc_sample, button_levels
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata relay, mode, LEDs, segments, save, temp
// cfg       in   cfg_valid_i / cfg_ready_o      cfg_index_i register, cfg_data_i value
//
// A sample runs from its transfer to a valid result through two 10-step shift-and-add
// passes of the quadratic, two constant adds, the update, 14 double-dabble steps and the load.
// A button scan skips the quadratic.
// One item is in flight at a time; the next is taken while the result register still waits.
// Reset restores the menu, relay and limits to their power-up values.
// A stalled output holds the finished result; the configuration port is always ready.
module hysteresis_thermostat_with_display (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic                           s_axis_tuser,   // kind
  input  logic [hts_pkg::InDataW-1:0]    s_axis_tdata,   // adc_sample, button_levels
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // relay_on, menu_mode, led_upper, led_lower, seg_left, seg_middle, seg_right,
  // save_strobe, save_value, temperature_centi
  output logic [hts_pkg::OutDataW-1:0]   m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [hts_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [hts_pkg::LimW-1:0]       cfg_data_i
);

  hts_pkg::state_e state_q, state_d;

  logic [hts_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic                         kind_q;
  logic [hts_pkg::AdcW-1:0]     x_q, x_d;
  logic [hts_pkg::BtnW-1:0]     lv_q;
  logic [hts_pkg::AccW-1:0]     acc_q, acc_d;
  logic [hts_pkg::MulW-1:0]     m_q, m_d;
  logic [hts_pkg::TempW-1:0]    val_q, val_d;
  logic [hts_pkg::BcdW-1:0]     bcd_q, bcd_d;
  logic                         lt1000_q, lt1000_d;
  logic                         lt10000_q, lt10000_d;

  logic [1:0]                   mode_q, mode_d;
  logic [hts_pkg::BtnW-1:0]     prev_q, prev_d;
  logic                         above_q, above_d;
  logic                         relay_q, relay_d;
  logic [hts_pkg::LimW-1:0]     upper_q, upper_d;
  logic [hts_pkg::LimW-1:0]     lower_q, lower_d;
  logic [hts_pkg::LimW-1:0]     sup_q, sup_d;
  logic [hts_pkg::LimW-1:0]     slo_q, slo_d;
  logic [hts_pkg::TempW-1:0]    temp_q, temp_d;
  logic [1:0]                   strobe_q, strobe_d;
  logic [hts_pkg::LimW-1:0]     sval_q, sval_d;

  logic                         out_valid_q, out_valid_d;
  logic [hts_pkg::OutDataW-1:0] out_data_q, out_data_d;

  logic                         in_xfer;
  logic                         out_free;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == hts_pkg::StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    logic [hts_pkg::TempW-1:0]  t;
    logic [hts_pkg::LimW+5:0]   lo50;
    logic [hts_pkg::LimW+5:0]   up50;
    logic [hts_pkg::BtnW-1:0]   edge_v;
    logic [hts_pkg::LimW-1:0]   u1;
    logic [hts_pkg::LimW-1:0]   l1;
    logic [hts_pkg::TempW-1:0]  shown;
    logic [hts_pkg::BcdW-1:0]   adj;
    logic [hts_pkg::SegW-1:0]   seg_l;
    logic [hts_pkg::SegW-1:0]   seg_m;
    logic [hts_pkg::SegW-1:0]   seg_r;

    state_d     = state_q;
    cnt_d       = cnt_q;
    x_d         = x_q;
    acc_d       = acc_q;
    m_d         = m_q;
    val_d       = val_q;
    bcd_d       = bcd_q;
    lt1000_d    = lt1000_q;
    lt10000_d   = lt10000_q;
    mode_d      = mode_q;
    prev_d      = prev_q;
    above_d     = above_q;
    relay_d     = relay_q;
    upper_d     = upper_q;
    lower_d     = lower_q;
    sup_d       = sup_q;
    slo_d       = slo_q;
    temp_d      = temp_q;
    strobe_d    = strobe_q;
    sval_d      = sval_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;

    t      = acc_q[hts_pkg::AccW-1:16];
    lo50   = hts_pkg::times50(lower_q);
    up50   = hts_pkg::times50(upper_q);
    edge_v = prev_q & ~lv_q;
    u1     = upper_q;
    l1     = lower_q;
    shown  = temp_q;
    adj    = bcd_q;
    seg_l  = '0;
    seg_m  = '0;
    seg_r  = '0;

    case (state_q)
      hts_pkg::StIdle: begin
        if (in_xfer) begin
          cnt_d    = '0;
          acc_d    = '0;
          x_d      = s_axis_tdata[hts_pkg::AdcW-1:0];
          strobe_d = hts_pkg::StrobeNone;
          sval_d   = '0;
          state_d  = s_axis_tuser ? hts_pkg::StUpd : hts_pkg::StMul1;
        end
      end
      hts_pkg::StMul1: begin
        acc_d = {acc_q[hts_pkg::AccW-2:0], 1'b0} + (x_q[hts_pkg::AdcW-1] ? hts_pkg::QuadA : '0);
        x_d   = {x_q[hts_pkg::AdcW-2:0], x_q[hts_pkg::AdcW-1]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == hts_pkg::MulLast) begin
          state_d = hts_pkg::StAddB;
        end
      end
      hts_pkg::StAddB: begin
        m_d     = acc_q[hts_pkg::MulW-1:0] + hts_pkg::QuadB;
        acc_d   = '0;
        cnt_d   = '0;
        state_d = hts_pkg::StMul2;
      end
      hts_pkg::StMul2: begin
        acc_d = {acc_q[hts_pkg::AccW-2:0], 1'b0}
              + (x_q[hts_pkg::AdcW-1] ? hts_pkg::AccW'(m_q) : '0);
        x_d   = {x_q[hts_pkg::AdcW-2:0], x_q[hts_pkg::AdcW-1]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == hts_pkg::MulLast) begin
          state_d = hts_pkg::StAddC;
        end
      end
      hts_pkg::StAddC: begin
        acc_d   = acc_q + hts_pkg::QuadC;
        state_d = hts_pkg::StUpd;
      end
      hts_pkg::StUpd: begin
        if (!kind_q) begin
          temp_d = t;
          if (t <= {1'b0, lo50}) begin
            relay_d = 1'b1;
            above_d = 1'b0;
          end else if (t <= {1'b0, up50}) begin
            relay_d = !above_q;
          end else begin
            relay_d = 1'b0;
            above_d = 1'b1;
          end
        end else begin
          prev_d = lv_q;
          if (mode_q == hts_pkg::ModeUpper) begin
            if (edge_v[0] && (u1 < hts_pkg::LimMax)) begin
              u1 = u1 + 1'b1;
            end
            if (edge_v[1] && (u1 > hts_pkg::LimMin)
                && ({1'b0, u1} >= ({1'b0, lower_q} + hts_pkg::LimGap))) begin
              u1 = u1 - 1'b1;
            end
          end else if (mode_q == hts_pkg::ModeLower) begin
            if (edge_v[0] && (l1 < hts_pkg::LimMax)
                && (({1'b0, l1} + hts_pkg::LimGap) <= {1'b0, upper_q})) begin
              l1 = l1 + 1'b1;
            end
            if (edge_v[1] && (l1 > hts_pkg::LimMin)) begin
              l1 = l1 - 1'b1;
            end
          end
          upper_d = u1;
          lower_d = l1;
          if (edge_v[2]) begin
            case (mode_q)
              hts_pkg::ModeUpper: begin
                mode_d = hts_pkg::ModeLower;
                if (u1 != sup_q) begin
                  strobe_d = hts_pkg::StrobeUpper;
                  sval_d   = u1;
                  sup_d    = u1;
                end
              end
              hts_pkg::ModeLower: begin
                mode_d = hts_pkg::ModeTemp;
                if (l1 != slo_q) begin
                  strobe_d = hts_pkg::StrobeLower;
                  sval_d   = l1;
                  slo_d    = l1;
                end
              end
              default: begin
                mode_d = hts_pkg::ModeUpper;
              end
            endcase
          end
        end
        case (mode_d)
          hts_pkg::ModeUpper: shown = {1'b0, hts_pkg::times50(upper_d)};
          hts_pkg::ModeLower: shown = {1'b0, hts_pkg::times50(lower_d)};
          default:            shown = temp_d;
        endcase
        val_d     = shown;
        bcd_d     = '0;
        cnt_d     = '0;
        lt1000_d  = (shown < hts_pkg::Thousand);
        lt10000_d = (shown < hts_pkg::TenThousand);
        state_d   = hts_pkg::StBcd;
      end
      hts_pkg::StBcd: begin
        for (int i = 0; i < 4; i++) begin
          if (bcd_q[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
          end
        end
        bcd_d = {adj[hts_pkg::BcdW-2:0], val_q[hts_pkg::TempW-1]};
        val_d = {val_q[hts_pkg::TempW-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == hts_pkg::BcdLast) begin
          state_d = hts_pkg::StDone;
        end
      end
      hts_pkg::StDone: begin
        if (lt1000_q) begin
          seg_l = hts_pkg::digit_seg(bcd_q[11:8]) | hts_pkg::SegPoint;
          seg_m = hts_pkg::digit_seg(bcd_q[7:4]);
          seg_r = hts_pkg::digit_seg(bcd_q[3:0]);
        end else if (lt10000_q) begin
          seg_l = hts_pkg::digit_seg(bcd_q[15:12]);
          seg_m = hts_pkg::digit_seg(bcd_q[11:8]) | hts_pkg::SegPoint;
          seg_r = hts_pkg::digit_seg(bcd_q[7:4]);
        end
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {4'b0, temp_q, sval_q, strobe_q, seg_r, seg_m, seg_l,
                         (mode_q == hts_pkg::ModeLower), (mode_q == hts_pkg::ModeUpper),
                         mode_q, relay_q};
          state_d     = hts_pkg::StIdle;
        end
      end
      default: begin
        state_d = hts_pkg::StIdle;
      end
    endcase

    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        hts_pkg::CfgLower: begin
          lower_d = cfg_data_i;
          slo_d   = cfg_data_i;
        end
        hts_pkg::CfgUpper: begin
          upper_d = cfg_data_i;
          sup_d   = cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hts_pkg::StIdle;
      cnt_q       <= '0;
      mode_q      <= hts_pkg::ModeTemp;
      prev_q      <= '1;
      above_q     <= 1'b0;
      relay_q     <= 1'b0;
      upper_q     <= hts_pkg::LimW'(44);
      lower_q     <= hts_pkg::LimW'(36);
      sup_q       <= hts_pkg::LimW'(44);
      slo_q       <= hts_pkg::LimW'(36);
      temp_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      mode_q      <= mode_d;
      prev_q      <= prev_d;
      above_q     <= above_d;
      relay_q     <= relay_d;
      upper_q     <= upper_d;
      lower_q     <= lower_d;
      sup_q       <= sup_d;
      slo_q       <= slo_d;
      temp_q      <= temp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q <= s_axis_tuser;
      lv_q   <= s_axis_tdata[hts_pkg::AdcW +: hts_pkg::BtnW];
    end
    x_q        <= x_d;
    acc_q      <= acc_d;
    m_q        <= m_d;
    val_q      <= val_d;
    bcd_q      <= bcd_d;
    lt1000_q   <= lt1000_d;
    lt10000_q  <= lt10000_d;
    strobe_q   <= strobe_d;
    sval_q     <= sval_d;
    out_data_q <= out_data_d;
  end

endmodule

### hw/rtl/hts_checker.sv
// Port-level checks of the hysteresis thermostat, bound to its top level.
module hts_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [hts_pkg::OutDataW-1:0] m_axis_tdata
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Stalled result changed before its transfer.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[3] == (m_axis_tdata[2:1] == hts_pkg::ModeUpper))
                   && (m_axis_tdata[4] == (m_axis_tdata[2:1] == hts_pkg::ModeLower)))
    else $error("Limit LEDs disagree with the menu mode.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[30:29] == hts_pkg::StrobeNone)
      |-> (m_axis_tdata[37:31] == 7'd0))
    else $error("Save value is nonzero without a save strobe.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[30:29] != 2'd3) && (m_axis_tdata[55:52] == 4'd0))
    else $error("Result carries an invalid strobe code or nonzero padding.");

endmodule

bind hysteresis_thermostat_with_display hts_checker u_hts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### dv/hysteresis_thermostat_with_display_test.sv
// Self-checking testbench of the hysteresis thermostat with limit menu and segment display.
`timescale 1ns / 1ps

module hysteresis_thermostat_with_display_test;
  import hts_pkg::*;

  localparam logic KindSample  = 1'b0;
  localparam logic KindButtons = 1'b1;
  localparam int unsigned BtnPlus   = 0;
  localparam int unsigned BtnMinus  = 1;
  localparam int unsigned BtnSelect = 2;
  localparam logic [BtnW-1:0] AllReleased = 3'b111;
  localparam int unsigned StepCeiling = 100;
  localparam int unsigned StepFloor   = 30;
  localparam int unsigned LimitGap    = 2;
  localparam int unsigned HalfToCenti = 50;
  localparam int unsigned IdleLimit    = 4000;
  localparam int unsigned LongHold     = 500;
  localparam int unsigned SettleCycles = 60;
  localparam int unsigned PhaseItems   = 250;
  localparam int unsigned NumPhases    = 7;
  localparam logic [SegW-1:0] SevenSeg [10] = '{
    8'h77, 8'h24, 8'h5D, 8'h6D, 8'h2E, 8'h6B, 8'h7B, 8'h25, 8'h7F, 8'h6F
  };

  typedef struct packed {
    logic            kind;
    logic [BtnW-1:0] levels;
    logic [AdcW-1:0] adc;
  } reading_t;

  typedef struct packed {
    logic [TempW-1:0] temp_centi;
    logic [LimW-1:0]  save_value;
    logic [1:0]       save_strobe;
    logic [SegW-1:0]  seg_right;
    logic [SegW-1:0]  seg_middle;
    logic [SegW-1:0]  seg_left;
    logic             led_lower;
    logic             led_upper;
    logic [1:0]       menu_mode;
    logic             relay_on;
  } panel_t;

  localparam int unsigned PanelW = $bits(panel_t);

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic                s_axis_tuser = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CfgLower;
  logic [LimW-1:0]     cfg_data_i = '0;

  hysteresis_thermostat_with_display dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [1:0]       mode_q = ModeTemp;
  logic [BtnW-1:0]  prev_q = AllReleased;
  logic             above_q = 1'b0;
  logic             relay_q = 1'b0;
  logic [LimW-1:0]  upper_q = 7'd44;
  logic [LimW-1:0]  lower_q = 7'd36;
  logic [LimW-1:0]  saved_upper_q = 7'd44;
  logic [LimW-1:0]  saved_lower_q = 7'd36;
  logic [TempW-1:0] temp_q = '0;

  reading_t    scan_queue[$];
  panel_t      pending_panels[$];
  reading_t    offered;
  reading_t    accepted;
  bit          in_fire = 1'b0;
  bit          steady = 1'b0;
  bit          long_hold_pending = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned idle_cycles = 0;
  int unsigned fail_count = 0;

  function automatic int unsigned centi_of(logic [AdcW-1:0] x);
    longint unsigned acc;
    acc = 64'd321 * x * x + 64'd353501 * x + 64'd51963494;
    return int'((acc >> 16) & 64'h3FFF);
  endfunction

  function automatic void show_value(input int unsigned v, output logic [SegW-1:0] left,
                                     output logic [SegW-1:0] middle,
                                     output logic [SegW-1:0] right);
    if (v < 1000) begin
      left   = SevenSeg[(v / 100) % 10] | SegPoint;
      middle = SevenSeg[(v / 10) % 10];
      right  = SevenSeg[v % 10];
    end else if (v < 10000) begin
      left   = SevenSeg[(v / 1000) % 10];
      middle = SevenSeg[(v / 100) % 10] | SegPoint;
      right  = SevenSeg[(v / 10) % 10];
    end else begin
      left   = '0;
      middle = '0;
      right  = '0;
    end
  endfunction

  function automatic panel_t step_thermostat(reading_t it);
    panel_t          p;
    int unsigned     t;
    int unsigned     shown;
    int unsigned     up;
    int unsigned     lo;
    logic [BtnW-1:0] pressed;
    p = '0;
    if (it.kind == KindSample) begin
      t = centi_of(it.adc);
      temp_q = t[TempW-1:0];
      if (t <= lower_q * HalfToCenti) begin
        relay_q = 1'b1;
        above_q = 1'b0;
      end else if (t <= upper_q * HalfToCenti) begin
        relay_q = ~above_q;
      end else begin
        relay_q = 1'b0;
        above_q = 1'b1;
      end
    end else begin
      pressed = prev_q & ~it.levels;
      prev_q = it.levels;
      up = upper_q;
      lo = lower_q;
      if (mode_q == ModeUpper) begin
        if (pressed[BtnPlus] && up < StepCeiling) up++;
        if (pressed[BtnMinus] && up > StepFloor && up >= lo + LimitGap) up--;
      end else if (mode_q == ModeLower) begin
        if (pressed[BtnPlus] && lo < StepCeiling && lo + LimitGap <= up) lo++;
        if (pressed[BtnMinus] && lo > StepFloor) lo--;
      end
      upper_q = up[LimW-1:0];
      lower_q = lo[LimW-1:0];
      if (pressed[BtnSelect]) begin
        case (mode_q)
          ModeUpper: begin
            mode_q = ModeLower;
            if (upper_q != saved_upper_q) begin
              p.save_strobe = StrobeUpper;
              p.save_value = upper_q;
              saved_upper_q = upper_q;
            end
          end
          ModeLower: begin
            mode_q = ModeTemp;
            if (lower_q != saved_lower_q) begin
              p.save_strobe = StrobeLower;
              p.save_value = lower_q;
              saved_lower_q = lower_q;
            end
          end
          default: mode_q = ModeUpper;
        endcase
      end
    end
    case (mode_q)
      ModeUpper: shown = upper_q * HalfToCenti;
      ModeLower: shown = lower_q * HalfToCenti;
      default:   shown = temp_q;
    endcase
    show_value(shown, p.seg_left, p.seg_middle, p.seg_right);
    p.relay_on = relay_q;
    p.menu_mode = mode_q;
    p.led_upper = (mode_q == ModeUpper);
    p.led_lower = (mode_q == ModeLower);
    p.temp_centi = temp_q;
    return p;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s expected %0d actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_panel(panel_t want, logic [OutDataW-1:0] raw);
    panel_t got;
    got = raw[PanelW-1:0];
    compare_field("relay_on", want.relay_on, got.relay_on);
    compare_field("menu_mode", want.menu_mode, got.menu_mode);
    compare_field("led_upper", want.led_upper, got.led_upper);
    compare_field("led_lower", want.led_lower, got.led_lower);
    compare_field("seg_left", want.seg_left, got.seg_left);
    compare_field("seg_middle", want.seg_middle, got.seg_middle);
    compare_field("seg_right", want.seg_right, got.seg_right);
    compare_field("save_strobe", want.save_strobe, got.save_strobe);
    compare_field("save_value", want.save_value, got.save_value);
    compare_field("temperature_centi", want.temp_centi, got.temp_centi);
    compare_field("tdata padding", '0, raw[OutDataW-1:PanelW]);
  endfunction

  function automatic int unsigned random_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic void push_item(logic kind, logic [AdcW-1:0] adc, logic [BtnW-1:0] levels);
    reading_t it;
    it.kind = kind;
    it.adc = adc;
    it.levels = levels;
    scan_queue.push_back(it);
  endfunction

  function automatic void push_sample(logic [AdcW-1:0] adc);
    push_item(KindSample, adc, BtnW'($urandom_range(0, 7)));
  endfunction

  function automatic void push_scan(logic [BtnW-1:0] levels);
    push_item(KindButtons, AdcW'($urandom_range(0, 1023)), levels);
  endfunction

  function automatic void push_press(int unsigned button);
    push_scan(AllReleased & ~(BtnW'(1) << button));
    push_scan(AllReleased);
  endfunction

  function automatic logic [AdcW-1:0] random_adc();
    if ($urandom_range(0, 1) == 1) return AdcW'($urandom_range(0, 1023));
    return AdcW'($urandom_range(0, 650));
  endfunction

  function automatic void queue_random_traffic(int unsigned count);
    int unsigned added;
    int unsigned choice;
    int unsigned reps;
    int unsigned button;
    added = 0;
    while (added < count) begin
      choice = $urandom_range(0, 99);
      if (choice < 35) begin
        push_sample(random_adc());
        added += 1;
      end else if (choice < 65) begin
        push_press($urandom_range(BtnPlus, BtnSelect));
        added += 2;
      end else if (choice < 75) begin
        reps = $urandom_range(1, 70);
        button = $urandom_range(BtnPlus, BtnMinus);
        repeat (reps) push_press(button);
        added += 2 * reps;
      end else if (choice < 87) begin
        reps = $urandom_range(1, 3);
        repeat (reps) push_scan(BtnW'($urandom_range(0, 7)));
        added += reps;
      end else begin
        button = $urandom_range(BtnPlus, BtnSelect);
        push_scan(AllReleased & ~(BtnW'(1) << button));
        push_scan(BtnW'($urandom_range(0, 7)) & ~(BtnW'(1) << button));
        push_scan(AllReleased);
        added += 3;
      end
    end
  endfunction

  function automatic void queue_directed();
    push_sample(10'd0);
    push_sample(10'd1023);
    push_sample(10'd190);
    push_sample(10'd230);
    push_sample(10'd190);
    push_sample(10'd100);
    push_scan(AllReleased);
    push_press(BtnPlus);
    push_press(BtnSelect);
    push_press(BtnPlus);
    push_press(BtnPlus);
    push_press(BtnMinus);
    push_scan(3'b000);
    push_scan(AllReleased);
    push_press(BtnMinus);
    push_press(BtnSelect);
    push_sample(10'd1023);
  endfunction

  task automatic write_limit(logic [CfgIdxW-1:0] index, logic [LimW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (index == CfgLower) begin
      lower_q = value;
      saved_lower_q = value;
    end else begin
      upper_q = value;
      saved_upper_q = value;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_for_quiet();
    while (scan_queue.size() != 0 || s_axis_tvalid || pending_panels.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_fire) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (scan_queue.size() > 0) begin
          offered = scan_queue.pop_front();
          s_axis_tuser <= offered.kind;
          s_axis_tdata <= InDataW'({offered.levels, offered.adc});
          s_axis_tvalid <= 1'b1;
          send_gap = random_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        recv_stall = LongHold;
        m_axis_tready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_stall = random_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_panels.size() == 0) begin
          $error("result transfer arrived with no expected result waiting");
          fail_count++;
        end else begin
          check_panel(pending_panels.pop_front(), m_axis_tdata);
        end
      end
      in_fire = s_axis_tvalid && s_axis_tready;
      if (in_fire) begin
        accepted.kind = s_axis_tuser;
        accepted.adc = s_axis_tdata[AdcW-1:0];
        accepted.levels = s_axis_tdata[AdcW+BtnW-1:AdcW];
        pending_panels.push_back(step_thermostat(accepted));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    queue_directed();
    wait_for_quiet();
    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        1: begin
          write_limit(CfgLower, 7'd30);
          write_limit(CfgUpper, 7'd100);
        end
        2: begin
          write_limit(CfgLower, 7'd127);
          write_limit(CfgUpper, 7'd2);
        end
        3: begin
          write_limit(CfgUpper, 7'd0);
          write_limit(CfgLower, 7'd0);
        end
        4: begin
          write_limit(CfgLower, 7'd2);
          write_limit(CfgUpper, 7'd127);
        end
        5: begin
          write_limit(CfgLower, LimW'($urandom_range(2, 127)));
          write_limit(CfgUpper, LimW'($urandom_range(2, 127)));
        end
        6: begin
          write_limit(CfgUpper, LimW'($urandom_range(60, 127)));
          write_limit(CfgLower, LimW'($urandom_range(2, 60)));
        end
        default: ;
      endcase
      steady = (phase == 3);
      queue_random_traffic(PhaseItems);
      if (phase == 2) long_hold_pending = 1'b1;
      wait_for_quiet();
    end
    if (fail_count == 0 && pending_panels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
